// ===== hdl/lfdc_pkg.sv =====
// Shared types, codes and reset constants for the line follow drive controller.
`timescale 1ns / 1ps

package lfdc_pkg;

   localparam int SAMPLE_WIDTH = 12;
   localparam int POWER_WIDTH  = 8;
   localparam int CODE_WIDTH   = 4;

   localparam logic [SAMPLE_WIDTH-1:0] THRESHOLD_RESET = 12'd1200;

   // Wheel power components
   localparam logic signed [POWER_WIDTH-1:0] FWD_SIDE      = 8'sd25;
   localparam logic signed [POWER_WIDTH-1:0] FWD_CENTER    = 8'sd50;
   localparam logic signed [POWER_WIDTH-1:0] FWD_RECOVER   = 8'sd10;
   localparam logic signed [POWER_WIDTH-1:0] TURN_SIDE     = 8'sd50;
   localparam logic signed [POWER_WIDTH-1:0] TURN_CORRECT  = 8'sd10;
   localparam logic signed [POWER_WIDTH-1:0] STRAFE_CORRECT = 8'sd10;
   localparam logic signed [POWER_WIDTH-1:0] TURN_CORNER   = 8'sd70;
   localparam logic signed [POWER_WIDTH-1:0] STRAFE_RECOVER = 8'sd30;
   localparam logic signed [POWER_WIDTH-1:0] TURN_RECOVER  = 8'sd20;

   // Last turn side codes (code 3 also reads as none)
   localparam logic [1:0] TURN_RIGHT = 2'd0;
   localparam logic [1:0] TURN_LEFT  = 2'd1;
   localparam logic [1:0] TURN_NONE  = 2'd2;

   // Last heading codes
   localparam logic [1:0] HEAD_RIGHT  = 2'd0;
   localparam logic [1:0] HEAD_LEFT   = 2'd1;
   localparam logic [1:0] HEAD_CENTER = 2'd2;
   localparam logic [1:0] HEAD_NONE   = 2'd3;

   // Motion codes
   localparam logic [CODE_WIDTH-1:0] MOTION_RIGHT         = 4'd0;
   localparam logic [CODE_WIDTH-1:0] MOTION_CENTER        = 4'd1;
   localparam logic [CODE_WIDTH-1:0] MOTION_LEFT          = 4'd2;
   localparam logic [CODE_WIDTH-1:0] MOTION_RECOVER_LEFT  = 4'd3;
   localparam logic [CODE_WIDTH-1:0] MOTION_RECOVER_RIGHT = 4'd4;
   localparam logic [CODE_WIDTH-1:0] MOTION_LOST          = 4'd5;
   localparam logic [CODE_WIDTH-1:0] MOTION_PIVOT_RIGHT   = 4'd6;
   localparam logic [CODE_WIDTH-1:0] MOTION_PIVOT_LEFT    = 4'd7;
   localparam logic [CODE_WIDTH-1:0] MOTION_PIVOT_CENTER  = 4'd8;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] left_sample;
      logic [SAMPLE_WIDTH-1:0] middle_sample;
      logic [SAMPLE_WIDTH-1:0] right_sample;
      logic [SAMPLE_WIDTH-1:0] front_left_sample;
      logic [SAMPLE_WIDTH-1:0] front_right_sample;
   } req_item_type;

   typedef struct packed {
      logic signed [POWER_WIDTH-1:0] front_left_power;
      logic signed [POWER_WIDTH-1:0] back_left_power;
      logic signed [POWER_WIDTH-1:0] front_right_power;
      logic signed [POWER_WIDTH-1:0] back_right_power;
      logic [CODE_WIDTH-1:0]         motion_code;
      logic                          corner_left_seen;
      logic                          corner_right_seen;
   } rsp_item_type;

   typedef struct packed {
      logic signed [POWER_WIDTH-1:0] forward;
      logic signed [POWER_WIDTH-1:0] strafe;
      logic signed [POWER_WIDTH-1:0] turn;
   } drive_cmd_type;

   typedef struct packed {
      logic       prev_front_left_white;
      logic       prev_front_right_white;
      logic       left_corner_latch;
      logic       right_corner_latch;
      logic       line_found;
      logic       line_dropped;
      logic [1:0] last_turn_side;
      logic [1:0] last_heading;
   } track_state_type;

   localparam track_state_type STATE_RESET = '{
      prev_front_left_white:  1'b0,
      prev_front_right_white: 1'b0,
      left_corner_latch:      1'b0,
      right_corner_latch:     1'b0,
      line_found:             1'b1,
      line_dropped:           1'b0,
      last_turn_side:         TURN_NONE,
      last_heading:           HEAD_NONE
   };

endpackage

// ===== hdl/lfdc_decide.sv =====
// Line rules: corner latches, drive powers, motion code and next tracking state.
`timescale 1ns / 1ps

module lfdc_decide import lfdc_pkg::*; (
   input  req_item_type            item,
   input  logic [SAMPLE_WIDTH-1:0] threshold,
   input  track_state_type         state_cur,
   output track_state_type         state_next,
   output drive_cmd_type           drive,
   output logic [CODE_WIDTH-1:0]   motion_code
);

   logic            left_seen;
   logic            middle_seen;
   logic            right_seen;
   track_state_type st;
   logic [CODE_WIDTH-1:0] pivot_code;

   assign left_seen   = item.left_sample   > threshold;
   assign middle_seen = item.middle_sample > threshold;
   assign right_seen  = item.right_sample  > threshold;

   // heading only matters when no rule fired, so it is still the stored one
   always_comb begin
      unique case (state_cur.last_heading)
         HEAD_RIGHT:  pivot_code = MOTION_PIVOT_RIGHT;
         HEAD_LEFT:   pivot_code = MOTION_PIVOT_LEFT;
         HEAD_CENTER: pivot_code = MOTION_PIVOT_CENTER;
         default:     pivot_code = MOTION_LOST;
      endcase
   end

   always_comb begin
      st = state_cur;
      // clear latches once the line has come back after a loss
      if (st.line_found && st.line_dropped) begin
         st.left_corner_latch  = 1'b0;
         st.right_corner_latch = 1'b0;
      end
      if (st.prev_front_left_white) begin
         st.left_corner_latch = 1'b1;
      end
      if (st.prev_front_right_white) begin
         st.right_corner_latch = 1'b1;
      end

      drive       = '0;
      motion_code = MOTION_LOST;

      if (right_seen) begin
         drive.forward     = FWD_SIDE;
         drive.turn        = TURN_SIDE;
         st.last_heading   = HEAD_RIGHT;
         st.last_turn_side = TURN_RIGHT;
         motion_code       = MOTION_RIGHT;
      end
      if (middle_seen) begin
         drive.forward = FWD_CENTER;
         drive.strafe  = '0;
         drive.turn    = '0;
         if (left_seen && !right_seen) begin
            drive.strafe = STRAFE_CORRECT;
            drive.turn   = -TURN_CORRECT;
         end else if (right_seen && !left_seen) begin
            drive.strafe = -STRAFE_CORRECT;
            drive.turn   = TURN_CORRECT;
         end
         motion_code     = MOTION_CENTER;
         st.last_heading = HEAD_CENTER;
      end
      if (left_seen) begin
         drive.forward     = FWD_SIDE;
         drive.strafe      = '0;
         drive.turn        = -TURN_SIDE;
         st.last_heading   = HEAD_LEFT;
         st.last_turn_side = TURN_LEFT;
         motion_code       = MOTION_LEFT;
      end

      if (!(left_seen || middle_seen || right_seen)) begin
         st.line_found   = 1'b0;
         st.line_dropped = 1'b1;
         drive           = '0;
         motion_code     = MOTION_LOST;
         priority if (st.left_corner_latch) begin
            drive.turn = TURN_CORNER;
         end else if (st.right_corner_latch) begin
            drive.turn = -TURN_CORNER;
         end else if (st.last_turn_side == TURN_LEFT) begin
            drive.forward = FWD_RECOVER;
            drive.strafe  = STRAFE_RECOVER;
            drive.turn    = -TURN_RECOVER;
            motion_code   = MOTION_RECOVER_LEFT;
         end else if (st.last_turn_side == TURN_RIGHT) begin
            drive.forward = FWD_RECOVER;
            drive.strafe  = -STRAFE_RECOVER;
            drive.turn    = TURN_RECOVER;
            motion_code   = MOTION_RECOVER_RIGHT;
         end else begin
            drive.turn  = -TURN_RECOVER;
            motion_code = pivot_code;
         end
      end else begin
         st.line_found = 1'b1;
      end
   end

   always_comb begin
      state_next = st;
      state_next.prev_front_left_white  = item.front_left_sample  > threshold;
      state_next.prev_front_right_white = item.front_right_sample > threshold;
   end

endmodule

// ===== hdl/lfdc_mix.sv =====
// Omni-wheel mixer: forward, turn and strafe into four wheel powers.
`timescale 1ns / 1ps

module lfdc_mix import lfdc_pkg::*; (
   input  drive_cmd_type                 drive,
   output logic signed [POWER_WIDTH-1:0] front_left_power,
   output logic signed [POWER_WIDTH-1:0] back_left_power,
   output logic signed [POWER_WIDTH-1:0] front_right_power,
   output logic signed [POWER_WIDTH-1:0] back_right_power
);

   assign front_left_power  = drive.forward + drive.turn + drive.strafe;
   assign back_left_power   = drive.forward + drive.turn - drive.strafe;
   assign front_right_power = drive.forward - drive.turn - drive.strafe;
   assign back_right_power  = drive.forward - drive.turn + drive.strafe;

endmodule

// ===== hdl/line_follow_drive_controller.sv =====
// An accepted item passes through the input register, then the result register, where it waits
// to be taken; the rule and mix logic between the two registers is single pass.
// Throughput: one item per cycle while the receiver does not stall.
// The input register moves on whenever the result register is empty or being taken.
// Reset (synchronous, active high): both registers empty, threshold 1200, tracking state to its
// power-up values (line found, no turn side, no heading, latches and corner bits clear).
`timescale 1ns / 1ps

module line_follow_drive_controller import lfdc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // sensor items in
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_item_type            req_data,
   // drive items out
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_data,
   // threshold register
   input  logic                    csr_write_enable,
   input  logic [SAMPLE_WIDTH-1:0] csr_write_data
);

   // Input register
   logic            in_valid_ff;
   logic            in_valid_in;
   req_item_type    in_item_ff;

   // Result register
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_item_type    out_item_ff;
   rsp_item_type    out_item_in;

   // Threshold and tracking state
   logic [SAMPLE_WIDTH-1:0] threshold_ff;
   track_state_type         state_ff;
   track_state_type         state_in;
   track_state_type         state_calc;

   drive_cmd_type           drive;
   logic [CODE_WIDTH-1:0]   motion_code;

   logic advance;
   logic req_take;

   // Advance the held item into the result register when that register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // Hold the requester only while an item waits that cannot move on.
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   // Tracking state moves exactly once per item, as it enters the result register.
   assign state_in     = advance ? state_calc : state_ff;

   lfdc_decide u_decide (
      .item        (in_item_ff),
      .threshold   (threshold_ff),
      .state_cur   (state_ff),
      .state_next  (state_calc),
      .drive       (drive),
      .motion_code (motion_code)
   );

   lfdc_mix u_mix (
      .drive             (drive),
      .front_left_power  (out_item_in.front_left_power),
      .back_left_power   (out_item_in.back_left_power),
      .front_right_power (out_item_in.front_right_power),
      .back_right_power  (out_item_in.back_right_power)
   );

   // Corner flags report the latches after this item's update.
   assign out_item_in.motion_code       = motion_code;
   assign out_item_in.corner_left_seen  = state_calc.left_corner_latch;
   assign out_item_in.corner_right_seen = state_calc.right_corner_latch;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         if (csr_write_enable) begin
            threshold_ff <= csr_write_data;
         end
      end
   end

   // Payload registers: load on accept, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the line follow drive controller.
`timescale 1ns / 1ps

module tb;
   import lfdc_pkg::*;

   // Generous bound: every item waiting out the sender's longest gap and a slow receiver
   localparam int CYCLE_LIMIT   = 200000;
   // Pipeline holds two items; leave a few spare edges after the last result
   localparam int SETTLE_CYCLES = 6;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_item_type  req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_item_type  rsp_data;
   logic          csr_write_enable;
   logic [SAMPLE_WIDTH-1:0] csr_write_data;

   line_follow_drive_controller dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Tracking state of the controller as the testbench sees it
   logic [SAMPLE_WIDTH-1:0] threshold_q;
   logic       front_left_white_q;
   logic       front_right_white_q;
   logic       left_latch_q;
   logic       right_latch_q;
   logic       line_found_q;
   logic       line_dropped_q;
   logic [1:0] turn_side_q;
   logic [1:0] heading_q;

   rsp_item_type drive_expect_q[$];
   int           mismatch_count;
   int           cycle_count;

   // Sender idling: bursts of random length with random gaps between them
   bit idle_enable;
   int burst_left;
   // Long receiver hold-off, picked up and counted down by the receiver process
   int receiver_hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort the run if the drive items stop coming
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      // Keep the log short once things go badly wrong
      if (mismatch_count <= 100)
         $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   // Work out the drive item for one sample set and advance the tracking state
   task automatic predict_drive(input req_item_type s);
      rsp_item_type d;
      logic l, m, r;
      int fwd, strafe, turn;
      logic [CODE_WIDTH-1:0] code;

      // A regained line after any earlier loss clears both corner latches
      if (line_found_q && line_dropped_q) begin
         left_latch_q  = 1'b0;
         right_latch_q = 1'b0;
      end
      // Corner bits stored on the previous item set their latches now
      if (front_left_white_q)
         left_latch_q = 1'b1;
      if (front_right_white_q)
         right_latch_q = 1'b1;

      l = s.left_sample > threshold_q;
      m = s.middle_sample > threshold_q;
      r = s.right_sample > threshold_q;

      fwd = 0;
      strafe = 0;
      turn = 0;
      code = MOTION_LOST;

      // Right, then centre, then left: each later rule overrides the earlier ones
      if (r) begin
         fwd = 25;
         turn = 50;
         heading_q = HEAD_RIGHT;
         turn_side_q = TURN_RIGHT;
         code = MOTION_RIGHT;
      end
      if (m) begin
         fwd = 50;
         strafe = 0;
         turn = 0;
         // Nudge towards a single side that also sees the line
         if (l && !r) begin
            strafe = 10;
            turn = -10;
         end else if (r && !l) begin
            strafe = -10;
            turn = 10;
         end
         code = MOTION_CENTER;
         heading_q = HEAD_CENTER;
      end
      if (l) begin
         fwd = 25;
         strafe = 0;
         turn = -50;
         heading_q = HEAD_LEFT;
         turn_side_q = TURN_LEFT;
         code = MOTION_LEFT;
      end

      if (!(l || m || r)) begin
         // Line lost: corner turn, then recovery strafe, then pivot
         line_found_q = 1'b0;
         line_dropped_q = 1'b1;
         fwd = 0;
         strafe = 0;
         turn = 0;
         code = MOTION_LOST;
         if (left_latch_q) begin
            turn = 70;
         end else if (right_latch_q) begin
            turn = -70;
         end else if (turn_side_q == TURN_LEFT) begin
            fwd = 10;
            strafe = 30;
            turn = -20;
            code = MOTION_RECOVER_LEFT;
         end else if (turn_side_q == TURN_RIGHT) begin
            fwd = 10;
            strafe = -30;
            turn = 20;
            code = MOTION_RECOVER_RIGHT;
         end else begin
            turn = -20;
            case (heading_q)
               HEAD_RIGHT:  code = MOTION_PIVOT_RIGHT;
               HEAD_LEFT:   code = MOTION_PIVOT_LEFT;
               HEAD_CENTER: code = MOTION_PIVOT_CENTER;
               default:     code = MOTION_LOST;
            endcase
         end
      end else begin
         line_found_q = 1'b1;
      end

      d.front_left_power  = 8'(fwd + turn + strafe);
      d.back_left_power   = 8'(fwd + turn - strafe);
      d.front_right_power = 8'(fwd - turn - strafe);
      d.back_right_power  = 8'(fwd - turn + strafe);
      d.motion_code       = code;
      d.corner_left_seen  = left_latch_q;
      d.corner_right_seen = right_latch_q;
      drive_expect_q.push_back(d);

      // Store the corner samples for the next item, against the current threshold
      front_left_white_q  = s.front_left_sample > threshold_q;
      front_right_white_q = s.front_right_sample > threshold_q;
   endtask

   // Check each drive item taken, then predict for each sample set taken at this edge
   always @(posedge clock) begin : drive_checker
      rsp_item_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (drive_expect_q.size() == 0) begin
               report_mismatch("drive item with none pending, motion_code",
                               int'(rsp_data.motion_code), 0);
            end else begin
               want = drive_expect_q.pop_front();
               check_field("front_left_power", int'(rsp_data.front_left_power),
                           int'(want.front_left_power));
               check_field("back_left_power", int'(rsp_data.back_left_power),
                           int'(want.back_left_power));
               check_field("front_right_power", int'(rsp_data.front_right_power),
                           int'(want.front_right_power));
               check_field("back_right_power", int'(rsp_data.back_right_power),
                           int'(want.back_right_power));
               check_field("motion_code", int'(rsp_data.motion_code),
                           int'(want.motion_code));
               check_field("corner_left_seen", int'(rsp_data.corner_left_seen),
                           int'(want.corner_left_seen));
               check_field("corner_right_seen", int'(rsp_data.corner_right_seen),
                           int'(want.corner_right_seen));
            end
         end
         if (req_valid && !req_stall)
            predict_drive(req_data);
      end
   end

   // Receiver: stall in modes of random length, or hold off for a requested stretch
   initial begin : receiver_pattern
      int mode;
      int mode_left;
      int hold_left;
      int beat;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      beat = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         beat++;
         if (receiver_hold_request > 0) begin
            hold_left = receiver_hold_request;
            receiver_hold_request = 0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 9) < 3);
               2:       rsp_stall <= (beat % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   // Offer one sample set and hold it until taken; then maybe pause between bursts
   task automatic offer_item(input req_item_type s);
      int gap;
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall);
      if (idle_enable) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid, let every pending drive item come out, then let the pipeline settle
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drive_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle
   task automatic write_threshold(input logic [SAMPLE_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      threshold_q = value;
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_item_type sample_set(input int l, input int m, input int r,
                                                input int fl, input int fr);
      req_item_type s;
      s.left_sample        = 12'(l);
      s.middle_sample      = 12'(m);
      s.right_sample       = 12'(r);
      s.front_left_sample  = 12'(fl);
      s.front_right_sample = 12'(fr);
      return s;
   endfunction

   // Pick a reading on the chosen side of the current threshold
   function automatic logic [SAMPLE_WIDTH-1:0] line_sample(input bit on_line);
      if (!on_line)
         return 12'($urandom_range(0, int'(threshold_q)));
      if (threshold_q == 12'hFFF)
         return 12'hFFF;
      return 12'($urandom_range(int'(threshold_q) + 1, 4095));
   endfunction

   // Mostly chosen line patterns with random readings; the rest raw noise
   function automatic req_item_type random_sample_set();
      req_item_type s;
      logic [63:0] raw;
      int pattern;
      if ($urandom_range(0, 9) < 2) begin
         raw = {$urandom, $urandom};
         s = raw[59:0];
      end else begin
         pattern = $urandom_range(0, 10);
         // Favour losing the line so corner turns and recoveries come often
         if (pattern > 7)
            pattern = 0;
         s.left_sample        = line_sample(pattern[2]);
         s.middle_sample      = line_sample(pattern[1]);
         s.right_sample       = line_sample(pattern[0]);
         s.front_left_sample  = line_sample($urandom_range(0, 99) < 20);
         s.front_right_sample = line_sample($urandom_range(0, 99) < 20);
      end
      return s;
   endfunction

   // Straight after reset: pivot with no heading, then pivot after a centre heading
   task automatic test_lost_after_reset();
      offer_item(sample_set(0, 1200, 0, 0, 0));
      offer_item(sample_set(1200, 1201, 0, 0, 0));
      offer_item(sample_set(0, 0, 0, 0, 0));
   endtask

   // Right and left rules alone, centre with one side, and left winning over the rest
   task automatic test_rule_priority();
      offer_item(sample_set(0, 0, 4095, 0, 0));
      offer_item(sample_set(4095, 4095, 0, 0, 0));
      offer_item(sample_set(0, 1201, 4095, 0, 0));
      offer_item(sample_set(4095, 4095, 4095, 0, 0));
      offer_item(sample_set(1201, 0, 1201, 0, 0));
      offer_item(sample_set(4095, 0, 0, 0, 0));
   endtask

   // Corner bits land one item late; left latch wins; latches clear on a regained line
   task automatic test_corner_turns();
      offer_item(sample_set(0, 4095, 0, 4095, 0));
      offer_item(sample_set(0, 0, 0, 0, 4095));
      offer_item(sample_set(0, 0, 0, 0, 0));
      offer_item(sample_set(0, 4095, 0, 4095, 4095));
      offer_item(sample_set(0, 0, 0, 0, 0));
      offer_item(sample_set(0, 4095, 0, 0, 4095));
      offer_item(sample_set(0, 0, 0, 0, 0));
   endtask

   // Recovery strafe after a left turn and after a right turn
   task automatic test_recovery();
      offer_item(sample_set(4095, 0, 0, 0, 0));
      offer_item(sample_set(0, 0, 0, 0, 0));
      offer_item(sample_set(0, 0, 4095, 0, 0));
      offer_item(sample_set(0, 0, 0, 0, 0));
   endtask

   // Lowest threshold: anything above zero counts; highest: nothing ever counts
   task automatic test_threshold_extremes();
      wait_until_idle();
      write_threshold(12'd0);
      offer_item(sample_set(1, 0, 0, 0, 1));
      offer_item(sample_set(0, 0, 0, 0, 0));
      wait_until_idle();
      write_threshold(12'hFFF);
      offer_item(sample_set(4095, 4095, 4095, 4095, 4095));
   endtask

   // Hold the receiver off for a long stretch while items keep coming back to back
   task automatic test_backpressure();
      wait_until_idle();
      write_threshold(THRESHOLD_RESET);
      idle_enable = 1'b0;
      receiver_hold_request = 60;
      repeat (30) offer_item(random_sample_set());
      idle_enable = 1'b1;
   endtask

   // Random sample sets over several thresholds, extremes among them
   task automatic test_random_sweep();
      int count;
      logic [SAMPLE_WIDTH-1:0] level;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       level = 12'd0;
            1:       level = 12'hFFF;
            7:       level = THRESHOLD_RESET;
            default: level = 12'($urandom_range(200, 3900));
         endcase
         count = (phase < 2) ? 40 : 100;
         wait_until_idle();
         write_threshold(level);
         for (int n = 0; n < count; n++) begin
            // Switch sender idling on and off every so often
            if (n % 25 == 0)
               idle_enable = ($urandom_range(0, 3) != 0);
            offer_item(random_sample_set());
         end
      end
   endtask

   initial begin : test_sequence
      // Drive every input from the start while reset is held
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= THRESHOLD_RESET;
      threshold_q         = THRESHOLD_RESET;
      front_left_white_q  = 1'b0;
      front_right_white_q = 1'b0;
      left_latch_q        = 1'b0;
      right_latch_q       = 1'b0;
      line_found_q        = 1'b1;
      line_dropped_q      = 1'b0;
      turn_side_q         = TURN_NONE;
      heading_q           = HEAD_NONE;
      mismatch_count = 0;
      cycle_count = 0;
      idle_enable = 1'b1;
      burst_left = 0;
      receiver_hold_request = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_lost_after_reset();
      test_rule_priority();
      test_corner_turns();
      test_recovery();
      test_threshold_extremes();
      test_backpressure();
      test_random_sweep();

      wait_until_idle();
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/lfdc_pkg.sv
hdl/lfdc_decide.sv
hdl/lfdc_mix.sv
hdl/line_follow_drive_controller.sv
tb/sv/tb.sv
